[rtl/sc2a_pkg.sv]
// ----------------------------------------------------------------------------
// sc2a_pkg
// Shared types, constants and lookup tables for the scan code translator.
// ----------------------------------------------------------------------------
package sc2a_pkg;

  localparam logic [7:0] PREFIX_BYTE  = 8'hE0;
  localparam logic [6:0] KEY_LCTRL    = 7'h1D;
  localparam logic [6:0] KEY_LSHIFT   = 7'h2A;
  localparam logic [6:0] KEY_RSHIFT   = 7'h36;
  localparam logic [6:0] COMMON_LIMIT = 7'h3A;

  typedef enum logic [1:0] {
    CLS_NONE       = 2'd0,
    CLS_COMMON     = 2'd1,
    CLS_SPECIAL    = 2'd2,
    CLS_FUNCTIONAL = 2'd3
  } cls_t;

  typedef struct packed {
    logic ctrl;
    logic shift;
  } mods_t;

  typedef struct packed {
    logic       en;
    logic [6:0] key;
    logic       released;
  } mod_upd_t;

  typedef struct packed {
    cls_t       key_class;
    logic       released;
    logic [6:0] key_code;
    logic [6:0] char_out;
  } result_t;

  function automatic cls_t classify(input logic [6:0] k);
    cls_t c;
    if (k == 7'h00) begin
      c = CLS_NONE;
    end else if (k == 7'h01 || k == KEY_LCTRL || k == KEY_LSHIFT || k == KEY_RSHIFT ||
                 k == 7'h38 || k == 7'h3A) begin
      c = CLS_SPECIAL;
    end else if ((k >= 7'h3B && k <= 7'h44) || k == 7'h57 || k == 7'h58) begin
      c = CLS_FUNCTIONAL;
    end else if (k < COMMON_LIMIT) begin
      c = CLS_COMMON;
    end else begin
      c = CLS_SPECIAL;
    end
    return c;
  endfunction

  function automatic logic [6:0] layout_plain(input logic [5:0] k);
    logic [6:0] c;
    case (k)
      6'h01: c = 7'h1B;
      6'h02: c = 7'h31;
      6'h03: c = 7'h32;
      6'h04: c = 7'h33;
      6'h05: c = 7'h34;
      6'h06: c = 7'h35;
      6'h07: c = 7'h36;
      6'h08: c = 7'h37;
      6'h09: c = 7'h38;
      6'h0A: c = 7'h39;
      6'h0B: c = 7'h30;
      6'h0C: c = 7'h2D;
      6'h0D: c = 7'h3D;
      6'h0E: c = 7'h08;
      6'h0F: c = 7'h09;
      6'h10: c = 7'h71;
      6'h11: c = 7'h77;
      6'h12: c = 7'h65;
      6'h13: c = 7'h72;
      6'h14: c = 7'h74;
      6'h15: c = 7'h79;
      6'h16: c = 7'h75;
      6'h17: c = 7'h69;
      6'h18: c = 7'h6F;
      6'h19: c = 7'h70;
      6'h1A: c = 7'h5B;
      6'h1B: c = 7'h5D;
      6'h1C: c = 7'h0A;
      6'h1E: c = 7'h61;
      6'h1F: c = 7'h73;
      6'h20: c = 7'h64;
      6'h21: c = 7'h66;
      6'h22: c = 7'h67;
      6'h23: c = 7'h68;
      6'h24: c = 7'h6A;
      6'h25: c = 7'h6B;
      6'h26: c = 7'h6C;
      6'h27: c = 7'h3B;
      6'h28: c = 7'h27;
      6'h29: c = 7'h60;
      6'h2B: c = 7'h5C;
      6'h2C: c = 7'h7A;
      6'h2D: c = 7'h78;
      6'h2E: c = 7'h63;
      6'h2F: c = 7'h76;
      6'h30: c = 7'h62;
      6'h31: c = 7'h6E;
      6'h32: c = 7'h6D;
      6'h33: c = 7'h2C;
      6'h34: c = 7'h2E;
      6'h35: c = 7'h2F;
      6'h37: c = 7'h2A;
      6'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] layout_shift(input logic [5:0] k);
    logic [6:0] c;
    case (k)
      6'h01: c = 7'h1B;
      6'h02: c = 7'h21;
      6'h03: c = 7'h40;
      6'h04: c = 7'h23;
      6'h05: c = 7'h24;
      6'h06: c = 7'h25;
      6'h07: c = 7'h5E;
      6'h08: c = 7'h26;
      6'h09: c = 7'h2A;
      6'h0A: c = 7'h28;
      6'h0B: c = 7'h29;
      6'h0C: c = 7'h5F;
      6'h0D: c = 7'h2B;
      6'h0E: c = 7'h08;
      6'h0F: c = 7'h09;
      6'h10: c = 7'h51;
      6'h11: c = 7'h57;
      6'h12: c = 7'h45;
      6'h13: c = 7'h52;
      6'h14: c = 7'h54;
      6'h15: c = 7'h59;
      6'h16: c = 7'h55;
      6'h17: c = 7'h49;
      6'h18: c = 7'h4F;
      6'h19: c = 7'h50;
      6'h1A: c = 7'h7B;
      6'h1B: c = 7'h7D;
      6'h1C: c = 7'h0A;
      6'h1E: c = 7'h41;
      6'h1F: c = 7'h53;
      6'h20: c = 7'h44;
      6'h21: c = 7'h46;
      6'h22: c = 7'h47;
      6'h23: c = 7'h48;
      6'h24: c = 7'h4A;
      6'h25: c = 7'h4B;
      6'h26: c = 7'h4C;
      6'h27: c = 7'h3A;
      6'h28: c = 7'h22;
      6'h29: c = 7'h7E;
      6'h2B: c = 7'h7C;
      6'h2C: c = 7'h5A;
      6'h2D: c = 7'h58;
      6'h2E: c = 7'h43;
      6'h2F: c = 7'h56;
      6'h30: c = 7'h42;
      6'h31: c = 7'h4E;
      6'h32: c = 7'h4D;
      6'h33: c = 7'h3C;
      6'h34: c = 7'h3E;
      6'h35: c = 7'h3F;
      6'h37: c = 7'h2A;
      6'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  // letters, '-' and '`' fold into 0x40..0x5F, which maps to 0x00..0x1F
  function automatic logic [6:0] ctrl_map(input logic [6:0] c);
    logic [6:0] v;
    logic [6:0] r;
    v = c;
    if (v >= 7'h61 && v <= 7'h7A) begin
      v = v - 7'h20;
    end
    if (v == 7'h2D) begin
      v = 7'h5F;
    end
    if (v == 7'h60) begin
      v = 7'h40;
    end
    if (v >= 7'h40 && v <= 7'h5F) begin
      r = v - 7'h40;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

[rtl/sc2a_lookup.sv]
// ----------------------------------------------------------------------------
// sc2a_lookup
// Key classification and layout lookup with shift and ctrl translation.
// ----------------------------------------------------------------------------
module sc2a_lookup
  import sc2a_pkg::*;
(
  input  logic [7:0] scan_byte,
  input  mods_t      mods,
  output result_t    res
);

  logic [6:0] key;
  cls_t       cls;
  logic [6:0] plain_c;
  logic [6:0] shift_c;

  assign key     = scan_byte[6:0];
  assign cls     = classify(key);
  assign plain_c = layout_plain(key[5:0]);
  assign shift_c = layout_shift(key[5:0]);

  always_comb begin
    res.key_class = cls;
    res.released  = scan_byte[7];
    res.key_code  = 7'h00;
    res.char_out  = 7'h00;
    if (cls == CLS_COMMON) begin
      res.key_code = plain_c;
      if (mods.ctrl) begin
        res.char_out = ctrl_map(plain_c);
      end else if (mods.shift) begin
        res.char_out = shift_c;
      end else begin
        res.char_out = plain_c;
      end
    end
  end

endmodule

[rtl/sc2a_mods.sv]
// ----------------------------------------------------------------------------
// sc2a_mods
// Held-modifier flags for ctrl and shift, updated as keys leave the pipe.
// ----------------------------------------------------------------------------
module sc2a_mods
  import sc2a_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mod_upd_t upd,
  output mods_t    mods
);

  mods_t mods_r;
  mods_t mods_nxt;

  always_comb begin
    mods_nxt = mods_r;
    if (upd.en) begin
      if (upd.key == KEY_LCTRL) begin
        mods_nxt.ctrl = ~upd.released;
      end
      if (upd.key == KEY_LSHIFT || upd.key == KEY_RSHIFT) begin
        mods_nxt.shift = ~upd.released;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r <= '0;
    end else begin
      mods_r <= mods_nxt;
    end
  end

  assign mods = mods_r;

endmodule

[rtl/scancode_to_ascii_translator.sv]
// ----------------------------------------------------------------------------
// scancode_to_ascii_translator
// Set-1 keyboard scan code bytes in, classified and translated keys out.
// ----------------------------------------------------------------------------
// One byte is taken per cycle and its result reaches the output through
// one input register, one lookup pass and one result register. A full
// result register still accepts a new byte into the input register; the
// input stalls only when both hold data. The 0xE0 prefix is taken and
// dropped. Left ctrl (and right ctrl, which arrives as 0xE0 0x1D) and both
// shift keys set their held flag on press and clear it on release; the flags
// take effect for the byte that follows.
module scancode_to_ascii_translator
  import sc2a_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] scan_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [6:0] key_code, [13:7] char_out, [15:14] zero
  output logic [2:0]  out_tuser   // [0] released, [2:1] key_class
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       out_valid_r;
  result_t    out_res_r;

  logic       adv;
  logic       in_fire;
  mods_t      mods;
  mod_upd_t   upd;
  result_t    res;

  assign adv       = ~out_valid_r | out_tready;
  assign in_tready = ~s1_valid_r | adv;
  assign in_fire   = in_tvalid & in_tready;

  assign upd.en       = adv & s1_valid_r;
  assign upd.key      = s1_byte_r[6:0];
  assign upd.released = s1_byte_r[7];

  sc2a_mods u_mods (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (upd),
    .mods  (mods)
  );

  sc2a_lookup u_lookup (
    .scan_byte (s1_byte_r),
    .mods      (mods),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_fire & (in_tdata != PREFIX_BYTE);
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
    end
    if (adv && s1_valid_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r.char_out, out_res_r.key_code};
  assign out_tuser  = {out_res_r.key_class, out_res_r.released};

  a_prefix_dropped : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tdata == PREFIX_BYTE |=> !s1_valid_r)
    else $error("prefix byte entered the pipe");

  a_noncommon_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.key_class != CLS_COMMON |-> out_tdata == 16'h0000)
    else $error("non-common key carries a character");

  a_ctrl_follows : assert property (@(posedge clk) disable iff (!rst_n)
    upd.en && upd.key == KEY_LCTRL |=> mods.ctrl == !$past(s1_byte_r[7]))
    else $error("ctrl flag not updated");

  a_s1_holds : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_byte_r))
    else $error("stalled input register changed");

endmodule
